// File: rtl/byte_ring_fifo_with_rewind_defines.svh
// Assertion macros for the byte ring FIFO with rewind
`ifndef BYTE_RING_FIFO_WITH_REWIND_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_REWIND_DEFINES_SVH

`ifndef SYNTHESIS
`define BRFR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("byte ring fifo: implication violated");
`define BRFR_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("byte ring fifo: forbidden condition seen");
`else
`define BRFR_ASSERT_IMPLY(label, ante, cons)
`define BRFR_ASSERT_NEVER(label, cond)
`endif

`endif

// File: rtl/brfr_pkg.sv
// Shared types and constants for the byte ring FIFO with rewind
package brfr_pkg;

  localparam int DEPTH_DEF    = 1024;
  localparam int MAX_READ_RUN = 64;
  localparam int CFG_W        = 11;
  localparam int RLEN_W       = 7;
  localparam int RWND_W       = 11;
  localparam int USED_W       = 10;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_PURGE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        wr_byte;
    logic [RLEN_W-1:0] read_length;
    logic [RWND_W-1:0] rewind_count;
  } item_t;

  typedef struct packed {
    logic [7:0]        rd_byte;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic              status;
    logic [USED_W-1:0] used_count;
  } result_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        wr_byte;
    logic [RLEN_W-1:0] run_len;
    logic [RWND_W-1:0] rewind_count;
  } q_ent_t;

  typedef struct packed {
    logic   vld;
    q_ent_t ent;
  } q_head_t;

endpackage

// File: rtl/brfr_front.sv
// Command intake: clamps read length and queues commands for the back end
module brfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  brfr_pkg::item_t   item_i,
  input  logic              pop_i,
  output brfr_pkg::q_head_t head_o
);

  brfr_pkg::q_ent_t ent_q [2];
  brfr_pkg::q_ent_t ent_in;
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_q != 2'd0);

  always_comb begin
    ent_in.cmd          = item_i.cmd;
    ent_in.wr_byte      = item_i.wr_byte;
    ent_in.rewind_count = item_i.rewind_count;
    if (32'(item_i.read_length) > 32'(brfr_pkg::MAX_READ_RUN)) begin
      ent_in.run_len = brfr_pkg::RLEN_W'(brfr_pkg::MAX_READ_RUN);
    end else begin
      ent_in.run_len = item_i.read_length;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= ent_in;
    end
  end

  assign head_o.vld = (cnt_q != 2'd0);
  assign head_o.ent = ent_q[rd_ptr_q];

endmodule

// File: rtl/brfr_back.sv
// Execution engine: byte store, ring positions, size register and result stream
module brfr_back #(
  parameter int DEPTH = brfr_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brfr_pkg::q_head_t          head_i,
  output logic                       pop_o,
  input  logic                       cfg_we_i,
  input  logic [brfr_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output brfr_pkg::result_t          result_o
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int SZ_W  = $clog2(DEPTH + 1);
  localparam int SW1   = SZ_W + 1;
  localparam int RL_W  = brfr_pkg::RLEN_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [7:0]       mem_q [DEPTH];
  logic             state_q, state_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [SZ_W-1:0]  sz_q, sz_d;
  logic [RL_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0] used_after_q, used_after_d;
  logic             res_vld_q, res_vld_d;
  logic             acc_q, acc_d;
  logic             st_q, st_d;
  logic             rd_pend_q;
  logic             rd_last_q;
  logic [7:0]       rdata_q;
  logic             mem_we;
  logic             rd_issue;

  logic [PTR_W-1:0] used;
  logic [SZ_W-1:0]  wp_nx;
  logic [SZ_W-1:0]  rp_nx;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic             full;
  logic [RL_W-1:0]  run_n;
  logic             too_far;
  logic [SW1-1:0]   rw_sum;
  logic [SW1-1:0]   rw_pos;
  logic [31:0]      cfg_val;

  always_comb begin
    if (wp_q >= rp_q) begin
      used = wp_q - rp_q;
    end else begin
      used = PTR_W'(sz_q - SZ_W'(rp_q) + SZ_W'(wp_q));
    end
    wp_nx  = SZ_W'(wp_q) + SZ_W'(1);
    rp_nx  = SZ_W'(rp_q) + SZ_W'(1);
    wp_inc = (wp_nx >= sz_q) ? '0 : PTR_W'(wp_nx);
    rp_inc = (rp_nx >= sz_q) ? '0 : PTR_W'(rp_nx);
    full   = ((SZ_W'(used) + SZ_W'(1)) == sz_q);
    if (32'(head_i.ent.run_len) > 32'(used)) begin
      run_n = RL_W'(used);
    end else begin
      run_n = head_i.ent.run_len;
    end
    too_far = 32'(head_i.ent.rewind_count) > 32'(sz_q);
    rw_sum  = SW1'(rp_q) + SW1'(sz_q) - SW1'(head_i.ent.rewind_count);
    rw_pos  = (rw_sum >= SW1'(sz_q)) ? (rw_sum - SW1'(sz_q)) : rw_sum;
    cfg_val = 32'(cfg_wdata_i);
    if (cfg_val == 32'd0) begin
      cfg_val = 32'd1;
    end else if (cfg_val > 32'(DEPTH)) begin
      cfg_val = 32'(DEPTH);
    end
  end

  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    sz_d         = sz_q;
    cnt_d        = cnt_q;
    used_after_d = used_after_q;
    res_vld_d    = 1'b0;
    acc_d        = acc_q;
    st_d         = st_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    rd_issue     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.vld) begin
          pop_o = 1'b1;
          acc_d = 1'b0;
          st_d  = 1'b0;
          case (head_i.ent.cmd)
            brfr_pkg::CMD_WRITE: begin
              res_vld_d = 1'b1;
              if (!full) begin
                mem_we = 1'b1;
                wp_d   = wp_inc;
                acc_d  = 1'b1;
              end
            end
            brfr_pkg::CMD_READ: begin
              if (run_n == '0) begin
                res_vld_d = 1'b1;
              end else begin
                cnt_d        = run_n;
                used_after_d = used - PTR_W'(run_n);
                state_d      = ST_RUN;
              end
            end
            brfr_pkg::CMD_REWIND: begin
              res_vld_d = 1'b1;
              if (too_far) begin
                st_d = 1'b1;
              end else begin
                rp_d = PTR_W'(rw_pos);
              end
            end
            brfr_pkg::CMD_PURGE: begin
              res_vld_d = 1'b1;
              rp_d      = '0;
              wp_d      = '0;
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        rd_issue = 1'b1;
        rp_d     = rp_inc;
        cnt_d    = cnt_q - RL_W'(1);
        if (cnt_q == RL_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      sz_d = SZ_W'(cfg_val);
      rp_d = '0;
      wp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rp_q         <= '0;
      wp_q         <= '0;
      sz_q         <= SZ_W'(DEPTH);
      cnt_q        <= '0;
      used_after_q <= '0;
      res_vld_q    <= 1'b0;
      acc_q        <= 1'b0;
      st_q         <= 1'b0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rp_q         <= rp_d;
      wp_q         <= wp_d;
      sz_q         <= sz_d;
      cnt_q        <= cnt_d;
      used_after_q <= used_after_d;
      res_vld_q    <= res_vld_d;
      acc_q        <= acc_d;
      st_q         <= st_d;
      rd_pend_q    <= rd_issue;
      rd_last_q    <= rd_issue && (cnt_q == RL_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= head_i.ent.wr_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  assign result_valid_o = res_vld_q || rd_pend_q;

  always_comb begin
    if (rd_pend_q) begin
      result_o.rd_byte    = rdata_q;
      result_o.byte_valid = 1'b1;
      result_o.last       = rd_last_q;
      result_o.accepted   = 1'b0;
      result_o.status     = 1'b0;
      result_o.used_count = brfr_pkg::USED_W'(used_after_q);
    end else begin
      result_o.rd_byte    = 8'd0;
      result_o.byte_valid = 1'b0;
      result_o.last       = 1'b1;
      result_o.accepted   = acc_q;
      result_o.status     = st_q;
      result_o.used_count = brfr_pkg::USED_W'(used);
    end
  end

endmodule

// File: rtl/byte_ring_fifo_with_rewind.sv
// Top level of the byte ring FIFO with rewind
//
// Commands enter a two-entry queue and are carried out one at a time by the
// execution engine. A write, rewind, purge or empty read is taken by the
// engine and its single result appears in the cycle after; a read of n
// bytes is taken in the idle state and then does one store read per byte in
// the run state, and each byte is shown once its store read is registered.
// busy is high while the queue holds two commands. Results are
// shown for exactly one cycle with result_valid_o and cannot be held off.
// At most size minus one bytes are held. Bytes in the store are undefined
// until written; rewinding over unwritten slots returns undefined bytes.
`include "byte_ring_fifo_with_rewind_defines.svh"

module byte_ring_fifo_with_rewind #(
  parameter int DEPTH = brfr_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  brfr_pkg::item_t            item_i,
  input  logic                       cfg_we_i,
  input  logic [brfr_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output brfr_pkg::result_t          result_o
);

  brfr_pkg::q_head_t head;
  logic              pop;

  brfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  brfr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `BRFR_ASSERT_IMPLY(a_pop_needs_head, pop, head.vld)
  `BRFR_ASSERT_IMPLY(a_busy_after_transfer, $rose(busy), $past(start))
  `BRFR_ASSERT_IMPLY(a_no_byte_is_last, result_valid_o && !result_o.byte_valid, result_o.last)
  `BRFR_ASSERT_NEVER(a_byte_with_flags, result_valid_o && result_o.byte_valid && (result_o.accepted || result_o.status))

endmodule
